[hdl/mvcc_snapshot_visibility_macros.svh]
// assertion macros for the snapshot visibility block
// the modules that use them must have signals named clk and rst in scope
`ifndef MVCC_SNAPSHOT_VISIBILITY_MACROS_SVH
`define MVCC_SNAPSHOT_VISIBILITY_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define MVCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvcc assertion failed");

// next-cycle implication
`define MVCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvcc assertion failed");

// plain invariant
`define MVCC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mvcc assertion failed");

`else

`define MVCC_ASSERT_IMP(lbl, ante, cons)
`define MVCC_ASSERT_NEXT(lbl, ante, cons)
`define MVCC_ASSERT_ALWAYS(lbl, cond)

`endif

`endif

[hdl/mvcc_pkg.sv]
package mvcc_pkg;

  // transaction id width
  localparam int ID_BITS = 32;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;
  // reserved code: no state change, zero result
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OWN_XID = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HORIZON = 1'd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [ID_BITS-1:0] entry_xid;
    logic [ID_BITS-1:0] row_xmin;
    logic [ID_BITS-1:0] row_xmax;
  } item_t;

  typedef struct packed {
    logic visible;
    logic list_full;
  } result_t;

  // what one cell hands to the next: a query token and running match flags
  typedef struct packed {
    logic tok;
    logic hit_min;
    logic hit_max;
  } link_t;

endpackage

[hdl/mvcc_snap_cell.sv]
module mvcc_snap_cell #(
  parameter int CNT_BITS = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [CNT_BITS-1:0]         count,
  input  logic                        wr_en,
  input  logic [mvcc_pkg::ID_BITS-1:0] wr_data,
  input  logic [mvcc_pkg::ID_BITS-1:0] query_min,
  input  logic [mvcc_pkg::ID_BITS-1:0] query_max,
  input  mvcc_pkg::link_t             link_in,
  output mvcc_pkg::link_t             link_out
);

  logic [mvcc_pkg::ID_BITS-1:0] entry;
  logic                         live;
  logic                         tok;
  logic                         hit_min;
  logic                         hit_max;

  // entry counts only while it sits below the fill count
  assign live = (count > CNT_BITS'(CELL_IDX));

  always_ff @(posedge clk) begin
    if (wr_en && (count == CNT_BITS'(CELL_IDX))) begin
      entry <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= link_in.tok;
    end
  end

  always_ff @(posedge clk) begin
    hit_min <= link_in.hit_min | (live && (entry == query_min));
    hit_max <= link_in.hit_max | (live && (entry == query_max));
  end

  assign link_out.tok     = tok;
  assign link_out.hit_min = hit_min;
  assign link_out.hit_max = hit_max;

endmodule

[hdl/mvcc_snapshot_visibility.sv]
// channel | signals                         | direction | handshake
// --------+---------------------------------+-----------+----------------------------
// item    | start, busy, item               | in        | taken when start && !busy
// result  | done, result                    | out       | one-cycle strobe on done
// config  | cfg_we, cfg_idx, cfg_data       | in        | written when cfg_we
//
// for clear, append and the unused code, done rises on the next cycle
// and busy stays low, so these words can come back to back.
// a check walks a token through the row of MAX_SNAPSHOT cells, one cell a cycle;
// its result comes once the token has left the last cell, busy high meanwhile.
// reset (synchronous, active high) zeroes both registers and the fill count; the
// stored ids are not cleared, only entries below the fill count are ever matched.
// the receiver cannot stall: each result is shown for exactly one cycle.
`include "mvcc_snapshot_visibility_macros.svh"

module mvcc_snapshot_visibility #(
  parameter int MAX_SNAPSHOT = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  mvcc_pkg::item_t                     item,
  // result channel
  output logic                                done,
  output mvcc_pkg::result_t                   result,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [mvcc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [mvcc_pkg::ID_BITS-1:0]        cfg_data
);

  // fill count must reach MAX_SNAPSHOT itself
  localparam int CNT_BITS = $clog2(MAX_SNAPSHOT + 1);

  logic [mvcc_pkg::ID_BITS-1:0] own_xid;
  logic [mvcc_pkg::ID_BITS-1:0] snapshot_horizon;
  logic [CNT_BITS-1:0]          count;
  logic                         launch;
  logic                         accept;
  logic                         append;
  logic                         list_at_max;

  // per-check flags, decided when the word is taken
  logic [mvcc_pkg::ID_BITS-1:0] q_xmin;
  logic [mvcc_pkg::ID_BITS-1:0] q_xmax;
  logic                         q_own_eq;
  logic                         q_above;
  logic                         q_xmax_nz;
  logic                         q_xmax_below;

  mvcc_pkg::link_t              chain [MAX_SNAPSHOT+1];
  logic [MAX_SNAPSHOT:0]        tok_vec;
  mvcc_pkg::link_t              chain_end;
  logic                         check_vis;

  assign accept      = start && !busy;
  assign list_at_max = (count == CNT_BITS'(MAX_SNAPSHOT));
  // an append is written into the cell whose index equals the fill count
  assign append      = accept && (item.cmd == mvcc_pkg::CMD_APPEND) && !list_at_max;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_xid          <= '0;
      snapshot_horizon <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mvcc_pkg::REG_OWN_XID: own_xid          <= cfg_data;
        mvcc_pkg::REG_HORIZON: snapshot_horizon <= cfg_data;
        default: ;
      endcase
    end
  end

  // row of cells; the token enters cell 0 the cycle after a check is taken
  assign chain[0].tok     = launch;
  assign chain[0].hit_min = 1'b0;
  assign chain[0].hit_max = 1'b0;

  for (genvar i = 0; i < MAX_SNAPSHOT; i++) begin : g_cell
    mvcc_snap_cell #(
      .CNT_BITS (CNT_BITS),
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .count     (count),
      .wr_en     (append),
      .wr_data   (item.entry_xid),
      .query_min (q_xmin),
      .query_max (q_xmax),
      .link_in   (chain[i]),
      .link_out  (chain[i+1])
    );
  end

  for (genvar i = 0; i <= MAX_SNAPSHOT; i++) begin : g_tok
    assign tok_vec[i] = chain[i].tok;
  end

  assign chain_end = chain[MAX_SNAPSHOT];

  // visibility rules in priority order: own creator, creator too new,
  // creator in progress, deleter in progress, deleter committed
  assign check_vis = q_own_eq ||
                     (!q_above && !chain_end.hit_min &&
                      (!q_xmax_nz || chain_end.hit_max || !q_xmax_below));

  // query operands, held for the whole walk
  always_ff @(posedge clk) begin
    if (accept) begin
      q_xmin       <= item.row_xmin;
      q_xmax       <= item.row_xmax;
      q_own_eq     <= (item.row_xmin == own_xid);
      q_above      <= (item.row_xmin >= snapshot_horizon);
      q_xmax_nz    <= (item.row_xmax != '0);
      q_xmax_below <= (item.row_xmax < snapshot_horizon);
    end
  end

  // command decode, fill count and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      busy   <= 1'b0;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      if (accept) begin
        unique case (item.cmd)
          mvcc_pkg::CMD_CLEAR: begin
            count  <= '0;
            done   <= 1'b1;
            result <= '0;
          end
          mvcc_pkg::CMD_APPEND: begin
            if (!list_at_max) begin
              count <= count + CNT_BITS'(1);
            end
            done             <= 1'b1;
            result.visible   <= 1'b0;
            result.list_full <= list_at_max;
          end
          mvcc_pkg::CMD_CHECK: begin
            busy   <= 1'b1;
            launch <= 1'b1;
          end
          default: begin
            // unused code: no state change, zero result
            done   <= 1'b1;
            result <= '0;
          end
        endcase
      end else if (chain_end.tok) begin
        // token left the last cell: the walk is over
        busy             <= 1'b0;
        done             <= 1'b1;
        result.visible   <= check_vis;
        result.list_full <= 1'b0;
      end
    end
  end

  // fill count never passes the list size
  `MVCC_ASSERT_ALWAYS(a_count_bound, count <= CNT_BITS'(MAX_SNAPSHOT))
  // at most one check walking the row
  `MVCC_ASSERT_ALWAYS(a_one_token, $onehot0(tok_vec))
  // a token in the row means the block reports busy
  `MVCC_ASSERT_IMP(a_tok_busy, tok_vec != '0, busy)
  // append into a full list is reported and leaves the count alone
  `MVCC_ASSERT_NEXT(a_full_drop, accept && item.cmd == mvcc_pkg::CMD_APPEND && list_at_max,
                    done && result.list_full && $stable(count))
  // a result never claims both flags
  `MVCC_ASSERT_IMP(a_excl_flags, done, !(result.visible && result.list_full))

endmodule
